/* rtl/sbmq_pkg.sv */
// ----------------------------------------------------------------------------
// sbmq_pkg
// Types and codes shared by the shared-buffer multi-queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbmq_pkg;

    // Field widths fixed by the interface
    localparam int QID_W  = 3;
    localparam int DOUT_W = 32;
    localparam int DIN_W  = 32;

    // Request codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* rtl/shared_buffer_multi_queue_top.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// Several FIFO queues sharing one slot store, linked through a free list.
//
// Usage:
//   Request channel (i_valid / o_ready): i_req_type selects enqueue or
//   dequeue, i_queue_id the queue (taken modulo QUEUES), i_data_in the value
//   to enqueue. Result channel (o_valid / i_ready): one result item per
//   request, carrying the dequeued value (zero otherwise), a status code
//   (ok, enqueue dropped on a full store, dequeue on an empty queue), and
//   store-full / queue-empty flags as they stand after the operation.
//   Timing: one request is in flight at a time. An enqueue onto an empty
//   queue or a full store and a dequeue from an empty queue go from S_LOOK
//   to S_DONE; an append passes S_LINK2 and a successful dequeue S_FETCH on
//   the way, and S_DONE loads the output register. The next request is taken
//   as the result is first presented. The extra states are due to the
//   registered read port of the queue-pointer and link RAMs and to the single
//   write port of the link RAM, which an append uses twice.
//   Reset: every queue empty, free list holds slots in ascending order.
//   Per-queue valid bits and a fill mark stand in for RAM initialisation,
//   so the block accepts requests straight out of reset.
//   Stall: the result sits in an output register; the next request is
//   taken while it waits, and its own result holds until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_buffer_multi_queue_top
    import sbmq_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int QUEUES     = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_req_type,
    input  wire logic        [QID_W-1:0]  i_queue_id,
    input  wire logic signed [DIN_W-1:0]  i_data_in,
    // result channel
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed      [DOUT_W-1:0] o_data_out,
    output logic             [1:0]        o_status,
    output logic                          o_store_full,
    output logic                          o_queue_empty
);

    // Pointer holds a slot number or SLOTS for null
    localparam int PW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_FETCH,
        S_LINK2,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [QW-1:0]       r_q;
    logic [DATA_WIDTH-1:0] r_din;
    logic [PW-1:0]       r_free_head;
    logic [PW-1:0]       r_wm;        // slots at or above this were never used
    logic [PW-1:0]       r_slot;
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic [QUEUES-1:0]   r_qvalid;
    // pending result
    logic [DOUT_W-1:0]   r_res_data;
    t_status             r_res_status;
    logic                r_res_full;
    logic                r_res_empty;
    // output register
    logic                r_ovalid;
    logic [DOUT_W-1:0]   r_data_out;
    t_status             r_status;
    logic                r_store_full;
    logic                r_queue_empty;

    // Queue index reduction
    logic [QID_W-1:0]    qid_mod;
    logic [QW-1:0]       qidx;

    always_comb begin
        qid_mod = i_queue_id;
        for (int k = 0; k < (1 << QID_W); k++) begin
            if (int'(qid_mod) >= QUEUES) begin
                qid_mod = qid_mod - QID_W'(QUEUES);
            end
        end
        qidx = QW'(qid_mod);
    end

    // RAM ports
    logic                  qram_we, qram_re;
    logic [QW-1:0]         qram_waddr, qram_raddr;
    logic [2*PW-1:0]       qram_wdata, qram_rdata;
    logic                  link_we, link_re;
    logic [AW-1:0]         link_waddr, link_raddr;
    logic [PW-1:0]         link_wdata, link_rdata;
    logic                  data_we, data_re;
    logic [AW-1:0]         data_waddr, data_raddr;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

    sbmq_ram #(.WIDTH(2 * PW), .DEPTH(QUEUES)) u_qram (
        .i_clk   (i_clk),
        .i_we    (qram_we),
        .i_waddr (qram_waddr),
        .i_wdata (qram_wdata),
        .i_re    (qram_re),
        .i_raddr (qram_raddr),
        .o_rdata (qram_rdata)
    );

    sbmq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    // Decoded lookups
    logic [PW-1:0] head, tail, enq_link;
    logic          head_nil, tail_nil, free_nil, enq_link_nil, deq_link_nil;

    always_comb begin
        // a queue never written reads as empty
        head = r_qvalid[r_q] ? qram_rdata[2*PW-1:PW] : NIL;
        tail = r_qvalid[r_q] ? qram_rdata[PW-1:0]    : NIL;
        head_nil = (head >= NIL);
        tail_nil = (tail >= NIL);
        free_nil = (r_free_head >= NIL);
        // an untouched slot still links to its successor
        enq_link = (r_free_head < r_wm) ? link_rdata : r_free_head + PW'(1);
        enq_link_nil = (enq_link >= NIL);
        deq_link_nil = (link_rdata >= NIL);
    end

    // Memory control
    always_comb begin
        qram_we    = 1'b0;
        qram_re    = 1'b0;
        qram_waddr = r_q;
        qram_raddr = qidx;
        qram_wdata = {NIL, NIL};
        link_we    = 1'b0;
        link_re    = 1'b0;
        link_waddr = r_free_head[AW-1:0];
        link_raddr = r_free_head[AW-1:0];
        link_wdata = NIL;
        data_we    = 1'b0;
        data_re    = 1'b0;
        data_waddr = r_free_head[AW-1:0];
        data_raddr = head[AW-1:0];
        data_wdata = r_din;
        unique case (r_state)
            S_IDLE: begin
                // fetch queue pointers and the free head's link up front
                qram_re = 1'b1;
                link_re = 1'b1;
            end
            S_LOOK: begin
                if (r_op == OP_ENQ) begin
                    if (!free_nil) begin
                        data_we = 1'b1;
                        link_we = 1'b1;
                        qram_we = 1'b1;
                        qram_wdata = (head_nil || tail_nil) ? {r_free_head, r_free_head}
                                                            : {head, r_free_head};
                    end
                end else if (!head_nil) begin
                    link_re    = 1'b1;
                    link_raddr = head[AW-1:0];
                    data_re    = 1'b1;
                end
            end
            S_FETCH: begin
                // return the slot to the free list
                link_we    = 1'b1;
                link_waddr = r_head[AW-1:0];
                link_wdata = r_free_head;
                qram_we    = 1'b1;
                qram_wdata = deq_link_nil ? {NIL, NIL} : {link_rdata, r_tail};
            end
            S_LINK2: begin
                // chain the new slot after the old tail
                link_we    = 1'b1;
                link_waddr = r_tail[AW-1:0];
                link_wdata = r_slot;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_wm        <= '0;
            r_qvalid    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            // drop the taken result unless a new one is loaded this cycle
            if (i_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_req_type;
                        r_q     <= qidx;
                        r_din   <= DATA_WIDTH'(i_data_in);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_tail     <= tail;
                    r_res_data <= '0;
                    if (r_op == OP_ENQ) begin
                        if (free_nil) begin
                            r_res_status <= ST_FULL;
                            r_res_full   <= 1'b1;
                            r_res_empty  <= head_nil;
                            r_state      <= S_DONE;
                        end else begin
                            r_slot      <= r_free_head;
                            r_free_head <= enq_link;
                            if (r_free_head == r_wm) begin
                                r_wm <= r_wm + PW'(1);
                            end
                            r_qvalid[r_q] <= 1'b1;
                            r_res_status  <= ST_OK;
                            r_res_full    <= enq_link_nil;
                            r_res_empty   <= 1'b0;
                            r_state <= (!head_nil && !tail_nil) ? S_LINK2 : S_DONE;
                        end
                    end else begin
                        if (head_nil) begin
                            r_res_status <= ST_EMPTY;
                            r_res_full   <= free_nil;
                            r_res_empty  <= 1'b1;
                            r_state      <= S_DONE;
                        end else begin
                            r_head  <= head;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_free_head  <= r_head;
                    r_res_data   <= DOUT_W'(data_rdata);
                    r_res_status <= ST_OK;
                    r_res_full   <= 1'b0;
                    r_res_empty  <= deq_link_nil;
                    r_state      <= S_DONE;
                end
                S_LINK2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register frees
                    if (!r_ovalid || i_ready) begin
                        r_ovalid      <= 1'b1;
                        r_data_out    <= r_res_data;
                        r_status      <= r_res_status;
                        r_store_full  <= r_res_full;
                        r_queue_empty <= r_res_empty;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_data_out    = r_data_out;
    assign o_status      = r_status;
    assign o_store_full  = r_store_full;
    assign o_queue_empty = r_queue_empty;

    // Checks
    a_wm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wm <= NIL)
        else $error("fill mark beyond slot count");

    a_fresh_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_free_head < NIL) && (r_free_head >= r_wm)) |-> (r_free_head == r_wm))
        else $error("free head skips untouched slots");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status == ST_FULL)) |-> r_store_full)
        else $error("dropped enqueue without store-full flag");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status == ST_EMPTY)) |-> (r_queue_empty && (r_data_out == '0)))
        else $error("failed dequeue reports data or non-empty queue");

endmodule

`default_nettype wire

/* rtl/sbmq_ram.sv */
// ----------------------------------------------------------------------------
// sbmq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for shared_buffer_multi_queue_top. A local model of the
// slot store keeps its own links, queue pointers and free list. It works out
// each result as its request is accepted. Every result item leaving the block
// is compared field by field, in order, against that prediction. Directed
// sequences cover empty and full corner cases. Random traffic then moves the
// store between empty and full under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import sbmq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_SLOTS   = 64;
    localparam int         N_QUEUES  = 8;
    localparam logic [6:0] NULL_PTR  = 7'd64;
    localparam int         IDLE_PCT  = 22;
    localparam int         STALL_MAX = 1000;   // cycles with no item moving
    localparam int         DRAIN_CYC = 10;     // allowance for stray result items

    // One predicted result item
    typedef struct packed {
        logic [31:0] data;
        t_status     status;
        logic        store_full;
        logic        queue_empty;
    } t_buffer_result;

    // ------------------------------------------------------------------
    // Block ports: every input has a known value from time zero
    // ------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic              i_req_type    = OP_ENQ;
    logic [QID_W-1:0]  i_queue_id    = '0;
    logic [DIN_W-1:0]  i_data_in     = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [DOUT_W-1:0] o_data_out;
    logic [1:0]        o_status;
    logic              o_store_full;
    logic              o_queue_empty;

    shared_buffer_multi_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_queue_id    (i_queue_id),
        .i_data_in     (i_data_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_store_full  (o_store_full),
        .o_queue_empty (o_queue_empty)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local copy of the store: slot values, slot links, queue pointers and
    // the free list, all at the block's widths
    // ------------------------------------------------------------------
    logic [31:0] slot_value [N_SLOTS];
    logic [6:0]  slot_next  [N_SLOTS];
    logic [6:0]  q_head     [N_QUEUES];
    logic [6:0]  q_tail     [N_QUEUES];
    logic [6:0]  free_slot;

    t_buffer_result predicted_results [$];

    bit no_idle = 1'b0;   // set for stretches with no gaps on either side
    int mismatches = 0;
    int results_checked = 0;
    int enq_total = 0, enq_dropped = 0, deq_total = 0, deq_on_empty = 0;

    function automatic bit is_null(logic [6:0] ptr);
        return ptr >= NULL_PTR;
    endfunction

    // Apply one request to the local store and return the result it causes
    function automatic t_buffer_result apply_request(logic op, logic [2:0] qid,
                                                     logic [31:0] din);
        t_buffer_result r;
        logic [6:0]     slot;
        r = '0;
        r.status = ST_OK;
        if (op == OP_ENQ) begin
            if (is_null(free_slot)) begin
                // store full: drop the item
                r.status = ST_FULL;
            end else begin
                slot = free_slot;
                free_slot = slot_next[slot];
                if (is_null(q_head[qid]) || is_null(q_tail[qid])) begin
                    q_head[qid] = slot;
                end else begin
                    slot_next[q_tail[qid]] = slot;
                end
                slot_next[slot]  = NULL_PTR;
                q_tail[qid]      = slot;
                slot_value[slot] = din;
            end
        end else begin
            if (is_null(q_head[qid])) begin
                r.status = ST_EMPTY;
            end else begin
                slot = q_head[qid];
                q_head[qid] = slot_next[slot];
                if (is_null(q_head[qid])) begin
                    q_head[qid] = NULL_PTR;
                    q_tail[qid] = NULL_PTR;
                end
                // push the freed slot onto the free list
                slot_next[slot] = free_slot;
                free_slot = slot;
                r.data = slot_value[slot];
            end
        end
        r.store_full  = is_null(free_slot);
        r.queue_empty = is_null(q_head[qid]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Send one request item. Entered and left at a falling edge; valid is
    // left high so that a following item goes out with no gap.
    // ------------------------------------------------------------------
    task automatic send_request(logic op, logic [2:0] qid, logic [31:0] din);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_queue_id <= qid;
        i_data_in  <= din;
        // hold the item until the block takes it
        do @(posedge i_clk); while (!o_ready);
        predicted_results.push_back(apply_request(op, qid, din));
        if (op == OP_ENQ) begin
            enq_total++;
            if (predicted_results[$].status == ST_FULL) enq_dropped++;
        end else begin
            deq_total++;
            if (predicted_results[$].status == ST_EMPTY) deq_on_empty++;
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls on ready, then check each item taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_buffer_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_results.size() == 0) begin
                $error("result item with nothing predicted: data_out %0h status %0d",
                       o_data_out, o_status);
                mismatches++;
            end else begin
                want = predicted_results.pop_front();
                results_checked++;
                if (o_data_out !== want.data) begin
                    $error("data_out: expected %0h, got %0h", want.data, o_data_out);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_store_full !== want.store_full) begin
                    $error("store_full: expected %0b, got %0b",
                           want.store_full, o_store_full);
                    mismatches++;
                end
                if (o_queue_empty !== want.queue_empty) begin
                    $error("queue_empty: expected %0b, got %0b",
                           want.queue_empty, o_queue_empty);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the data field on the outermost queues, dequeue from empty
    task automatic test_directed();
        logic [31:0] edge_values [6];
        edge_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                        32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        send_request(OP_DEQ, 3'd0, 32'hFFFF_FFFF);   // empty at reset
        send_request(OP_DEQ, 3'd7, 32'h1234_5678);
        foreach (edge_values[k]) begin
            send_request(OP_ENQ, 3'd0, edge_values[k]);
            send_request(OP_ENQ, 3'd7, ~edge_values[k]);
        end
        // drain both, one extra on each to see the empty status again
        for (int k = 0; k < 7; k++) begin
            send_request(OP_DEQ, 3'd0, 32'h0);
            send_request(OP_DEQ, 3'd7, 32'h0);
        end
    endtask

    // Fill every slot, push past full, then drain it all round robin
    task automatic test_fill_and_drain();
        for (int k = 0; k < N_SLOTS + 3; k++) begin
            send_request(OP_ENQ, 3'(k % N_QUEUES), $urandom());
        end
        for (int k = 0; k < N_SLOTS + 4; k++) begin
            send_request(OP_DEQ, 3'(k % N_QUEUES), $urandom());
        end
    endtask

    // No gaps on either side, one or two queues: exercise back-to-back
    // requests on the same pointers
    task automatic test_back_to_back(int count);
        no_idle = 1'b1;
        for (int k = 0; k < count; k++) begin
            send_request($urandom_range(1) ? OP_DEQ : OP_ENQ,
                         3'($urandom_range(1)), $urandom());
        end
        no_idle = 1'b0;
    endtask

    // Random traffic in blocks; each block has its own enqueue share and
    // queue spread, so the store swings between empty and full
    task automatic test_random_traffic(int count);
        int          enq_pct;
        bit          focused;
        logic [2:0]  base_q;
        logic [2:0]  qid;
        logic [31:0] din;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(4))
                    0:       enq_pct = 85;
                    1:       enq_pct = 65;
                    2:       enq_pct = 50;
                    3:       enq_pct = 35;
                    default: enq_pct = 15;
                endcase
                focused = $urandom_range(2) == 0;
                base_q  = 3'($urandom_range(7));
            end
            qid = focused ? base_q + 3'($urandom_range(1)) : 3'($urandom_range(7));
            din = $urandom();
            if ($urandom_range(15) == 0) begin
                case ($urandom_range(3))
                    0:       din = 32'h8000_0000;
                    1:       din = 32'h7FFF_FFFF;
                    2:       din = 32'h0000_0000;
                    default: din = 32'hFFFF_FFFF;
                endcase
            end
            send_request($urandom_range(99) < enq_pct ? OP_ENQ : OP_DEQ, qid, din);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // local store as it stands after reset: free chain in slot order
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_value[s] = '0;
            slot_next[s]  = 7'(s + 1);
        end
        for (int q = 0; q < N_QUEUES; q++) begin
            q_head[q] = NULL_PTR;
            q_tail[q] = NULL_PTR;
        end
        free_slot = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_back_to_back(240);
        test_random_traffic(1250);
        i_valid <= 1'b0;

        // let every predicted result come out, then allow for strays
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d enqueues (%0d dropped on a full store) and %0d dequeues",
                 enq_total, enq_dropped, deq_total);
        $display("(%0d on an empty queue); %0d result items checked, %0d mismatches",
                 deq_on_empty, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
